// ===== rtl/tpsrd_pkg.sv =====
package tpsrd_pkg;

	localparam logic [7:0] ALIGN_MARKER = 8'hf6;
	localparam logic [7:0] MARKER_RESET = 8'hf3;
	localparam int unsigned TRITS_PER_BYTE = 5;

	typedef logic [TRITS_PER_BYTE-1:0][1:0] trits_t;

	typedef struct packed {
		logic        valid;
		logic [7:0]  data;
		trits_t      trits;
	} in_beat_t;

	function automatic trits_t split_trits(input logic [7:0] b);
		trits_t     t;
		logic [7:0] r;
		r = b;
		if (r >= 8'd243) begin
			t[4] = 2'd0;
			r = r - 8'd243;
		end else if (r >= 8'd162) begin
			t[4] = 2'd2;
			r = r - 8'd162;
		end else if (r >= 8'd81) begin
			t[4] = 2'd1;
			r = r - 8'd81;
		end else begin
			t[4] = 2'd0;
		end
		if (r >= 8'd54) begin
			t[3] = 2'd2;
			r = r - 8'd54;
		end else if (r >= 8'd27) begin
			t[3] = 2'd1;
			r = r - 8'd27;
		end else begin
			t[3] = 2'd0;
		end
		if (r >= 8'd18) begin
			t[2] = 2'd2;
			r = r - 8'd18;
		end else if (r >= 8'd9) begin
			t[2] = 2'd1;
			r = r - 8'd9;
		end else begin
			t[2] = 2'd0;
		end
		if (r >= 8'd6) begin
			t[1] = 2'd2;
			r = r - 8'd6;
		end else if (r >= 8'd3) begin
			t[1] = 2'd1;
			r = r - 8'd3;
		end else begin
			t[1] = 2'd0;
		end
		t[0] = r[1:0];
		return t;
	endfunction

endpackage

// ===== rtl/tpsrd_in_stage.sv =====
module tpsrd_in_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [7:0]         s_axis_tdata,
	input  logic               consume,
	output tpsrd_pkg::in_beat_t beat
);

	logic                valid_s1;
	logic [7:0]          data_s1;
	tpsrd_pkg::trits_t   trits_s1;

	assign s_axis_tready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			data_s1  <= s_axis_tdata;
			trits_s1 <= tpsrd_pkg::split_trits(s_axis_tdata);
		end
	end

	assign beat.valid = valid_s1;
	assign beat.data  = data_s1;
	assign beat.trits = trits_s1;

endmodule

// ===== rtl/tpsrd_core.sv =====
module tpsrd_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [7:0]         cfg_wr_data,
	input  tpsrd_pkg::in_beat_t beat,
	output logic               consume,
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [39:0]        m_axis_tdata,
	output logic               m_axis_tuser,
	output logic               m_axis_tlast
);

	localparam logic [1:0] PH_HUNT   = 2'd0;
	localparam logic [1:0] PH_WIDTH  = 2'd1;
	localparam logic [1:0] PH_HEIGHT = 2'd2;
	localparam logic [1:0] PH_DATA   = 2'd3;
	localparam logic [2:0] IDX_LAST  = 3'(tpsrd_pkg::TRITS_PER_BYTE - 1);

	logic [1:0] phase_q;
	logic [7:0] marker_q;
	logic [7:0] width_q;
	logic [7:0] height_q;
	logic [8:0] col_q;
	logic [8:0] row_q;
	logic [2:0] idx_q;

	logic       out_valid_q;
	logic       status_q;
	logic [7:0] shape_width_q;
	logic [7:0] shape_height_q;
	logic [8:0] cell_col_q;
	logic [8:0] cell_row_q;
	logic       is_point_q;
	logic       is_disallowed_q;
	logic       record_end_q;
	logic       last_q;

	logic       out_free;
	logic       step;
	logic       emit;
	logic       err;
	logic [1:0] digit;
	logic [9:0] row_inc;
	logic [9:0] col_inc;
	logic       row_wrap;
	logic       done;
	logic       byte_last;

	assign out_free  = !out_valid_q || m_axis_tready;
	assign step      = beat.valid && out_free;
	assign digit     = beat.trits[idx_q];
	assign row_inc   = {1'b0, row_q} + 10'd1;
	assign col_inc   = {1'b0, col_q} + 10'd1;
	assign row_wrap  = row_inc > ({2'b00, height_q} + 10'd1);
	assign done      = row_wrap && (col_inc > ({2'b00, width_q} + 10'd1));
	assign byte_last = done || (idx_q == IDX_LAST);
	assign err       = (phase_q == PH_HUNT) && (beat.data != marker_q)
		&& (beat.data != tpsrd_pkg::ALIGN_MARKER);
	assign emit      = step && (err || (phase_q == PH_DATA));
	assign consume   = step && ((phase_q != PH_DATA) || byte_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker_q <= tpsrd_pkg::MARKER_RESET;
		end else if (cfg_wr_en) begin
			marker_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			width_q  <= 8'd0;
			height_q <= 8'd0;
			col_q    <= 9'd0;
			row_q    <= 9'd0;
			idx_q    <= 3'd0;
		end else if (step) begin
			case (phase_q)
				PH_HUNT: begin
					if (beat.data == marker_q) begin
						phase_q <= PH_WIDTH;
					end
				end
				PH_WIDTH: begin
					width_q <= beat.data;
					phase_q <= PH_HEIGHT;
				end
				PH_HEIGHT: begin
					height_q <= beat.data;
					col_q    <= 9'd0;
					row_q    <= 9'd0;
					idx_q    <= 3'd0;
					phase_q  <= PH_DATA;
				end
				PH_DATA: begin
					idx_q <= byte_last ? 3'd0 : idx_q + 3'd1;
					if (done) begin
						phase_q <= PH_HUNT;
						col_q   <= 9'd0;
						row_q   <= 9'd0;
					end else if (row_wrap) begin
						row_q <= 9'd0;
						col_q <= col_inc[8:0];
					end else begin
						row_q <= row_inc[8:0];
					end
				end
				default: begin
					phase_q <= PH_HUNT;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (err) begin
				status_q        <= 1'b1;
				shape_width_q   <= 8'd0;
				shape_height_q  <= 8'd0;
				cell_col_q      <= 9'd0;
				cell_row_q      <= 9'd0;
				is_point_q      <= 1'b0;
				is_disallowed_q <= 1'b0;
				record_end_q    <= 1'b0;
				last_q          <= 1'b1;
			end else begin
				status_q        <= 1'b0;
				shape_width_q   <= width_q;
				shape_height_q  <= height_q;
				cell_col_q      <= col_q;
				cell_row_q      <= row_q;
				is_point_q      <= (digit == 2'd1);
				is_disallowed_q <= (digit == 2'd1) || (digit == 2'd2);
				record_end_q    <= done;
				last_q          <= byte_last;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = status_q;
	assign m_axis_tlast  = last_q;
	assign m_axis_tdata  = {3'b000, record_end_q, is_disallowed_q, is_point_q,
		cell_row_q, cell_col_q, shape_height_q, shape_width_q};

endmodule

// ===== rtl/trit_packed_shape_record_decoder.sv =====
// Shape record decoder for a trit-packed byte stream.
// Input beats (s_axis) carry one raw byte each. In header hunt, align marker
// bytes are skipped and the byte equal to record_marker opens a record; any
// other byte yields one error beat (tuser = 1, tlast = 1). The next two
// bytes set width and height and yield nothing. Each data byte then yields
// up to five cell beats, one per base-3 digit, least significant first,
// scanned column-major over (width+2) x (height+2) cells; the final cell
// carries record_end and the block returns to header hunt.
// Output beats (m_axis) leave one per cycle from a result register while the receiver is ready;
// tlast marks the final beat caused by an input byte.
// A data byte yields its cell beats one after another from the single cell
// emitter, and the next input byte is taken as its last cell beat is emitted.
// An input register holds the next byte while a result waits, so a stalled
// receiver only holds the pipe; nothing is dropped.
// Reset clears the phase, the scan position and width/height to zero and
// loads record_marker with 0xF3. cfg_wr_en writes record_marker directly.
module trit_packed_shape_record_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] stream_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // [7:0] shape_width, [15:8] shape_height,
	                                   // [24:16] cell_col, [33:25] cell_row,
	                                   // [34] is_point, [35] is_disallowed,
	                                   // [36] record_end, [39:37] zero
	output logic        m_axis_tuser,  // [0] status
	output logic        m_axis_tlast   // last
);

	tpsrd_pkg::in_beat_t beat;
	logic                consume;

	tpsrd_in_stage u_in_stage (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.consume       (consume),
		.beat          (beat)
	);

	tpsrd_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.beat          (beat),
		.consume       (consume),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

// ===== tb/sv/shape_cell_checker.sv =====
module shape_cell_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,
	input  logic        m_tuser,
	input  logic        m_tlast,
	output int          pending_beats,
	output int          mismatch_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic STATUS_CELL       = 1'b0;
	localparam logic STATUS_BAD_HEADER = 1'b1;
	localparam int   MAX_REPORTS       = 10;

	typedef enum logic [1:0] {
		SEEK_HEADER,
		TAKE_WIDTH,
		TAKE_HEIGHT,
		TAKE_CELLS
	} scan_phase_t;

	typedef struct packed {
		logic       status;
		logic       last;
		logic [2:0] pad;
		logic       rec_end;
		logic       disallowed;
		logic       point;
		logic [8:0] row;
		logic [8:0] col;
		logic [7:0] height;
		logic [7:0] width;
	} cell_beat_t;

	cell_beat_t  cell_queue[$];
	cell_beat_t  got_beat;
	cell_beat_t  want_beat;
	scan_phase_t scan_phase;
	logic [7:0]  record_marker_q;
	int unsigned shape_w;
	int unsigned shape_h;
	int unsigned col_pos;
	int unsigned row_pos;
	int          fails;

	function automatic string beat_text(input cell_beat_t b);
		return $sformatf(
			"st=%0b w=%0d h=%0d col=%0d row=%0d pt=%0b dis=%0b end=%0b last=%0b pad=%0h",
			b.status, b.width, b.height, b.col, b.row, b.point, b.disallowed,
			b.rec_end, b.last, b.pad);
	endfunction

	function automatic void decode_byte(input logic [7:0] b);
		cell_beat_t  r;
		int unsigned v;
		int unsigned digit;
		logic        done;
		case (scan_phase)
			SEEK_HEADER: begin
				if (b == record_marker_q) begin
					scan_phase = TAKE_WIDTH;
				end else if (b != tpsrd_pkg::ALIGN_MARKER) begin
					r = '0;
					r.status = STATUS_BAD_HEADER;
					r.last = 1'b1;
					cell_queue.push_back(r);
				end
			end
			TAKE_WIDTH: begin
				shape_w = b;
				scan_phase = TAKE_HEIGHT;
			end
			TAKE_HEIGHT: begin
				shape_h = b;
				col_pos = 0;
				row_pos = 0;
				scan_phase = TAKE_CELLS;
			end
			default: begin
				v = b;
				done = 1'b0;
				for (int i = 0; i < tpsrd_pkg::TRITS_PER_BYTE && !done; i++) begin
					digit = v % 3;
					v = v / 3;
					r = '0;
					r.status = STATUS_CELL;
					r.width = 8'(shape_w);
					r.height = 8'(shape_h);
					r.col = 9'(col_pos);
					r.row = 9'(row_pos);
					r.point = (digit == 1);
					r.disallowed = (digit != 0);
					row_pos++;
					if (row_pos > shape_h + 1) begin
						row_pos = 0;
						col_pos++;
						if (col_pos > shape_w + 1)
							done = 1'b1;
					end
					r.rec_end = done;
					r.last = done || (i == tpsrd_pkg::TRITS_PER_BYTE - 1);
					cell_queue.push_back(r);
				end
				if (done) begin
					scan_phase = SEEK_HEADER;
					col_pos = 0;
					row_pos = 0;
				end
			end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			record_marker_q = tpsrd_pkg::MARKER_RESET;
			scan_phase = SEEK_HEADER;
			shape_w = 0;
			shape_h = 0;
			col_pos = 0;
			row_pos = 0;
			fails = 0;
			cell_queue.delete();
			pending_beats <= 0;
			mismatch_count <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_beat = cell_beat_t'({m_tuser, m_tlast, m_tdata});
				if (cell_queue.size() == 0) begin
					if (fails < MAX_REPORTS)
						$display("%t unexpected result beat: %s", $realtime,
							beat_text(got_beat));
					fails++;
				end else begin
					want_beat = cell_queue.pop_front();
					if (got_beat !== want_beat) begin
						if (fails < MAX_REPORTS)
							$display("%t mismatch\n  expected %s\n  actual   %s",
								$realtime, beat_text(want_beat), beat_text(got_beat));
						fails++;
					end
				end
			end
			if (cfg_wr_en)
				record_marker_q = cfg_wr_data;
			if (s_tvalid && s_tready)
				decode_byte(s_tdata);
			pending_beats <= cell_queue.size();
			mismatch_count <= fails;
		end
	end

endmodule

// ===== tb/sv/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_PHASES    = 5;
	localparam int PHASE_ITEMS   = 16;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES   = 400;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [7:0]  cfg_wr_data = 8'h00;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        m_axis_tlast;

	int          pending_beats;
	int          mismatch_count;
	int          tx_idle_pct = 15;
	int          rx_idle_pct = 49;
	int          hold_asks = 0;
	int          hold_seen = 0;
	int          hold_left = 0;
	int          items_sent = 0;
	logic [7:0]  cur_marker = tpsrd_pkg::MARKER_RESET;

	trit_packed_shape_record_decoder u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	shape_cell_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.s_tvalid       (s_axis_tvalid),
		.s_tready       (s_axis_tready),
		.s_tdata        (s_axis_tdata),
		.m_tvalid       (m_axis_tvalid),
		.m_tready       (m_axis_tready),
		.m_tdata        (m_axis_tdata),
		.m_tuser        (m_axis_tuser),
		.m_tlast        (m_axis_tlast),
		.pending_beats  (pending_beats),
		.mismatch_count (mismatch_count)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("** trit_packed_shape_record_decoder: FAILED **");
		$finish;
	end

	// hold off the receiver for a long stretch on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (hold_seen != hold_asks) begin
				hold_seen++;
				hold_left = HOLD_CYCLES;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending_beats != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_marker(input logic [7:0] v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cur_marker = v;
	endtask

	function automatic int cell_bytes(input int w, input int h);
		return ((w + 2) * (h + 2) + 4) / 5;
	endfunction

	task automatic send_record(input int w, input int h, input int nbytes);
		send_byte(cur_marker);
		send_byte(8'(w));
		send_byte(8'(h));
		repeat (nbytes) send_byte(8'($urandom_range(0, 255)));
		items_sent += 3 + nbytes;
	endtask

	initial begin : stimulus
		int         pick;
		int         w;
		int         h;
		int         nbytes;
		int         item_goal;
		logic [7:0] noise;
		logic [7:0] phase_marker [NUM_PHASES];

		phase_marker[0] = tpsrd_pkg::MARKER_RESET;
		phase_marker[1] = 8'h00;
		phase_marker[2] = 8'hff;
		phase_marker[3] = tpsrd_pkg::ALIGN_MARKER;
		phase_marker[4] = 8'($urandom_range(0, 255));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: header errors, align skip, partial bytes, all digit values
		send_byte(8'h00);
		send_byte(8'hff);
		send_byte(tpsrd_pkg::ALIGN_MARKER);
		send_byte(tpsrd_pkg::MARKER_RESET);
		send_byte(8'd0);
		send_byte(8'd1);
		send_byte(8'hff);
		send_byte(8'h00);
		send_byte(tpsrd_pkg::MARKER_RESET);
		send_byte(8'd1);
		send_byte(8'd0);
		send_byte(8'hf2);
		send_byte(8'h79);
		send_byte(tpsrd_pkg::MARKER_RESET);
		send_byte(8'd0);
		send_byte(8'd0);
		send_byte(8'h00);
		send_byte(tpsrd_pkg::ALIGN_MARKER);
		send_byte(8'h12);
		drain();

		for (int p = 0; p < NUM_PHASES; p++) begin
			case ((p * 3) / NUM_PHASES)
				0: begin
					tx_idle_pct = 15;
					rx_idle_pct = 49;
				end
				1: begin
					tx_idle_pct = 49;
					rx_idle_pct = 15;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			write_marker(phase_marker[p]);
			if (p == 0) begin
				send_record(255, 0, cell_bytes(255, 0));
				send_record(0, 255, cell_bytes(0, 255));
			end
			item_goal = items_sent + PHASE_ITEMS;
			while (items_sent < item_goal) begin
				pick = $urandom_range(0, 99);
				if (pick < 15) begin
					repeat ($urandom_range(1, 3)) begin
						noise = ($urandom_range(0, 3) == 0) ? tpsrd_pkg::ALIGN_MARKER
							: 8'($urandom_range(0, 255));
						send_byte(noise);
						if (noise != tpsrd_pkg::ALIGN_MARKER
							|| cur_marker == tpsrd_pkg::ALIGN_MARKER)
							items_sent++;
					end
				end else begin
					pick = $urandom_range(0, 99);
					if (pick < 3) begin
						w = ($urandom_range(0, 1) == 0) ? $urandom_range(200, 255) : 0;
						h = (w == 0) ? $urandom_range(200, 255) : 0;
					end else if (pick < 10) begin
						w = $urandom_range(0, 20);
						h = $urandom_range(0, 20);
					end else begin
						w = $urandom_range(0, 4);
						h = $urandom_range(0, 4);
					end
					nbytes = cell_bytes(w, h);
					if ($urandom_range(0, 99) < 8)
						nbytes = $urandom_range(0, nbytes - 1);
					if (cur_marker != tpsrd_pkg::ALIGN_MARKER && $urandom_range(0, 3) == 0)
						send_byte(tpsrd_pkg::ALIGN_MARKER);
					send_record(w, h, nbytes);
				end
				if (p == 1 && hold_asks == 0 && items_sent >= item_goal - PHASE_ITEMS / 2)
					hold_asks++;
			end
			drain();
		end

		@(negedge clk);
		if (mismatch_count == 0 && pending_beats == 0) begin
			$display("** trit_packed_shape_record_decoder: PASSED **");
		end else begin
			$display("** trit_packed_shape_record_decoder: FAILED **");
		end
		$finish;
	end

endmodule
